// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers for the interrupt dispatch core, clocked on clk_i,
// disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define PID_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pid assertion failed");

`define PID_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("pid forbidden condition seen");

`else

`define PID_ASSERT(lbl, prop)

`define PID_ASSERT_NEVER(lbl, cond)

`endif

`endif

// ===== rtl/core/pid_pkg.sv =====
// ----------------------------------------------------------------------------
// pid_pkg
// shared types, codes and the fixed source table of the interrupt dispatch
// ----------------------------------------------------------------------------
package pid_pkg;

  typedef enum logic [1:0] {
    OP_SET_REQ    = 2'd0,
    OP_RAISE_EXC  = 2'd1,
    OP_RAISE_TRAP = 2'd2,
    OP_POLL       = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_TRAP   = 3'd1,
    KIND_EXC    = 3'd2,
    KIND_NMI    = 3'd3,
    KIND_SOURCE = 3'd4
  } kind_e;

  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_PRIO_A = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRIO_B = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_PRIO_C = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PRIO_D = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_PIN_EN = 3'd4;

  localparam logic [1:0] EXC_KIND_MAX   = 2'd2;
  localparam logic [2:0] NMI_MASK_LEVEL = 3'd7;

  localparam int unsigned TableSources = 21;
  localparam int unsigned PinIrq0Src   = 1;
  localparam int unsigned PinIrq1Src   = 2;

  typedef struct packed {
    logic [3:0][7:0] prio_word;
    logic [1:0]      pin_en;
  } cfg_t;

  typedef struct packed {
    logic       taken;
    kind_e      kind;
    logic [4:0] which;
    logic       mask_write;
    logic [2:0] new_mask;
    logic       wakeup;
  } res_t;

  // dispatchable, priority word select, upper nibble
  typedef struct packed {
    logic       disp;
    logic [1:0] word;
    logic       hi;
  } src_entry_t;

  localparam src_entry_t SRC_TAB [TableSources] = '{
    '{1'b0, 2'd0, 1'b0}, '{1'b1, 2'd0, 1'b1}, '{1'b1, 2'd0, 1'b0},
    '{1'b0, 2'd0, 1'b0}, '{1'b1, 2'd1, 1'b1}, '{1'b1, 2'd1, 1'b1},
    '{1'b1, 2'd1, 1'b1}, '{1'b0, 2'd0, 1'b0}, '{1'b1, 2'd1, 1'b0},
    '{1'b1, 2'd1, 1'b0}, '{1'b1, 2'd1, 1'b0}, '{1'b0, 2'd0, 1'b0},
    '{1'b1, 2'd2, 1'b1}, '{1'b1, 2'd2, 1'b1}, '{1'b1, 2'd2, 1'b1},
    '{1'b1, 2'd2, 1'b0}, '{1'b1, 2'd2, 1'b0}, '{1'b1, 2'd2, 1'b0},
    '{1'b1, 2'd3, 1'b0}, '{1'b1, 2'd3, 1'b1}, '{1'b1, 2'd3, 1'b1}
  };

endpackage

// ===== rtl/core/pid_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pid_cfg_regs
// priority words and pin enable register file
// ----------------------------------------------------------------------------
module pid_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [pid_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [7:0]                   cfg_data_i,
  output pid_pkg::cfg_t                cfg_o
);
  import pid_pkg::*;

  cfg_t cfg_d, cfg_q;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PRIO_A: cfg_d.prio_word[0] = cfg_data_i;
        CFG_PRIO_B: cfg_d.prio_word[1] = cfg_data_i;
        CFG_PRIO_C: cfg_d.prio_word[2] = cfg_data_i;
        CFG_PRIO_D: cfg_d.prio_word[3] = cfg_data_i;
        CFG_PIN_EN: cfg_d.pin_en       = cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/pid_arbiter.sv =====
// ----------------------------------------------------------------------------
// pid_arbiter
// poll selection: lowest trap, exception, nmi, lowest eligible source
// ----------------------------------------------------------------------------
module pid_arbiter #(
  parameter int unsigned NUM_SOURCES = 21,
  parameter int unsigned NUM_TRAPS   = 16
) (
  input  logic [NUM_SOURCES-1:0] src_pend_i,
  input  logic [NUM_TRAPS-1:0]   trap_pend_i,
  input  logic                   exc_valid_i,
  input  logic [1:0]             exc_code_i,
  input  logic [2:0]             cmask_i,
  input  pid_pkg::cfg_t          cfg_i,
  output logic [NUM_TRAPS-1:0]   trap_low_o,
  output pid_pkg::res_t          sel_o
);
  import pid_pkg::*;

  logic [NUM_SOURCES-1:0] elig;
  logic [NUM_SOURCES-1:0] src_low;
  logic [2:0]             lvl_vec [NUM_SOURCES];
  logic [4:0]             trap_idx;
  logic [4:0]             src_idx;
  logic [2:0]             src_lvl;

  assign elig[0]    = 1'b0;
  assign lvl_vec[0] = '0;

  for (genvar j = 1; j < NUM_SOURCES; j++) begin : g_src
    if (j < TableSources && SRC_TAB[j].disp) begin : g_tab
      localparam logic [1:0] Word = SRC_TAB[j].word;
      localparam logic       Hi   = SRC_TAB[j].hi;
      logic en;
      assign en = (j == PinIrq0Src) ? cfg_i.pin_en[0] :
                  (j == PinIrq1Src) ? cfg_i.pin_en[1] : 1'b1;
      assign lvl_vec[j] = Hi ? cfg_i.prio_word[Word][6:4] : cfg_i.prio_word[Word][2:0];
      assign elig[j]    = src_pend_i[j] && en && (lvl_vec[j] > cmask_i);
    end else begin : g_none
      assign lvl_vec[j] = '0;
      assign elig[j]    = 1'b0;
    end
  end

  // isolate lowest set bit
  assign trap_low_o = trap_pend_i & (~trap_pend_i + NUM_TRAPS'(1));
  assign src_low    = elig & (~elig + NUM_SOURCES'(1));

  always_comb begin
    trap_idx = '0;
    src_idx  = '0;
    src_lvl  = '0;
    for (int j = 0; j < NUM_TRAPS; j++) begin
      if (trap_low_o[j]) trap_idx = trap_idx | 5'(j);
    end
    for (int j = 0; j < NUM_SOURCES; j++) begin
      if (src_low[j]) begin
        src_idx = src_idx | 5'(j);
        src_lvl = src_lvl | lvl_vec[j];
      end
    end
  end

  always_comb begin
    sel_o = '0;
    priority if (|trap_pend_i) begin
      sel_o.taken = 1'b1;
      sel_o.kind  = KIND_TRAP;
      sel_o.which = trap_idx;
    end else if (exc_valid_i) begin
      sel_o.taken = 1'b1;
      sel_o.kind  = KIND_EXC;
      sel_o.which = {3'b000, exc_code_i};
    end else if (src_pend_i[0]) begin
      sel_o.taken      = 1'b1;
      sel_o.kind       = KIND_NMI;
      sel_o.mask_write = 1'b1;
      sel_o.new_mask   = NMI_MASK_LEVEL;
    end else if (|elig) begin
      sel_o.taken      = 1'b1;
      sel_o.kind       = KIND_SOURCE;
      sel_o.which      = src_idx;
      sel_o.mask_write = 1'b1;
      sel_o.new_mask   = src_lvl;
    end else begin
      sel_o = '0;
    end
  end

endmodule

// ===== rtl/core/priority_interrupt_dispatch_top.sv =====
// ----------------------------------------------------------------------------
// priority_interrupt_dispatch_top
// interrupt arbiter: source requests, traps, exceptions and poll dispatch
// ----------------------------------------------------------------------------
// Takes one item per clock while the output is not stalled, and returns exactly one
// result per item: the item is held in the input register, then the pending
// state is read, updated and the result registered in a single pass through
// the priority logic. Back-to-back items see each other's state updates.
// Configuration writes are registered and should only be issued while
// no item is in flight.
`include "assert_macros.svh"

module priority_interrupt_dispatch_top #(
  parameter int unsigned NUM_SOURCES = 21,
  parameter int unsigned NUM_TRAPS   = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [pid_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                  cfg_data_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // source_index, request_level, exception_kind, trap_number,
  // current_mask_level, zero pad
  input  logic [15:0]                 s_axis_tdata,
  // opcode
  input  logic [1:0]                  s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // taken, dispatch_which, mask_write, new_mask_level, wakeup, zero pad
  output logic [15:0]                 m_axis_tdata,
  // dispatch_kind
  output logic [2:0]                  m_axis_tuser
);
  import pid_pkg::*;

  cfg_t                   cfg;
  logic                   in_valid_q;
  logic [15:0]            in_data_q;
  logic [1:0]             in_user_q;
  logic                   out_valid_q;
  res_t                   res_d, res_q;
  logic                   advance;

  logic [NUM_SOURCES-1:0] src_pend_d, src_pend_q;
  logic [NUM_TRAPS-1:0]   trap_pend_d, trap_pend_q;
  logic                   exc_valid_d, exc_valid_q;
  logic [1:0]             exc_code_d, exc_code_q;

  opcode_e                op;
  logic [4:0]             src;
  logic                   lvl;
  logic [1:0]             exc;
  logic [3:0]             trap;
  logic [2:0]             cmask;
  logic [NUM_SOURCES-1:0] src_hit;
  logic [NUM_TRAPS-1:0]   trap_hit;
  logic [NUM_TRAPS-1:0]   trap_low;
  res_t                   sel;
  logic                   poll_trap;
  logic                   poll_exc;

  pid_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata;
      in_user_q <= s_axis_tuser;
    end
  end

  assign op    = opcode_e'(in_user_q);
  assign src   = in_data_q[4:0];
  assign lvl   = in_data_q[5];
  assign exc   = in_data_q[7:6];
  assign trap  = in_data_q[11:8];
  assign cmask = in_data_q[14:12];

  always_comb begin
    for (int j = 0; j < NUM_SOURCES; j++) begin
      src_hit[j] = (32'(src) == j);
    end
    for (int j = 0; j < NUM_TRAPS; j++) begin
      trap_hit[j] = (32'(trap) == j);
    end
  end

  pid_arbiter #(
    .NUM_SOURCES (NUM_SOURCES),
    .NUM_TRAPS   (NUM_TRAPS)
  ) u_arb (
    .src_pend_i  (src_pend_q),
    .trap_pend_i (trap_pend_q),
    .exc_valid_i (exc_valid_q),
    .exc_code_i  (exc_code_q),
    .cmask_i     (cmask),
    .cfg_i       (cfg),
    .trap_low_o  (trap_low),
    .sel_o       (sel)
  );

  always_comb begin
    src_pend_d  = src_pend_q;
    trap_pend_d = trap_pend_q;
    exc_valid_d = exc_valid_q;
    exc_code_d  = exc_code_q;
    res_d       = '0;
    unique case (op)
      OP_SET_REQ: begin
        if (|src_hit) begin
          src_pend_d   = lvl ? (src_pend_q | src_hit) : (src_pend_q & ~src_hit);
          res_d.wakeup = lvl;
        end
      end
      OP_RAISE_EXC: begin
        if (exc <= EXC_KIND_MAX) begin
          exc_valid_d  = 1'b1;
          exc_code_d   = exc;
          res_d.wakeup = 1'b1;
        end
      end
      OP_RAISE_TRAP: begin
        if (|trap_hit) begin
          trap_pend_d  = trap_pend_q | trap_hit;
          res_d.wakeup = 1'b1;
        end
      end
      OP_POLL: begin
        res_d = sel;
        if (sel.kind == KIND_TRAP) begin
          trap_pend_d = trap_pend_q & ~trap_low;
        end
        if (sel.kind == KIND_EXC) begin
          exc_valid_d = 1'b0;
          exc_code_d  = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_pend_q  <= '0;
      trap_pend_q <= '0;
      exc_valid_q <= 1'b0;
      exc_code_q  <= '0;
    end else if (advance) begin
      src_pend_q  <= src_pend_d;
      trap_pend_q <= trap_pend_d;
      exc_valid_q <= exc_valid_d;
      exc_code_q  <= exc_code_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b00000, res_q.wakeup, res_q.new_mask, res_q.mask_write,
                          res_q.which, res_q.taken};
  assign m_axis_tuser  = res_q.kind;

  assign poll_trap = advance && (op == OP_POLL) && (sel.kind == KIND_TRAP);
  assign poll_exc  = advance && (op == OP_POLL) && (sel.kind == KIND_EXC);

  `PID_ASSERT(a_trap_cleared, poll_trap |=> ((trap_pend_q & $past(trap_low)) == '0))
  `PID_ASSERT(a_exc_cleared, poll_exc |=> !exc_valid_q)
  `PID_ASSERT_NEVER(a_taken_wake, out_valid_q && res_q.taken && res_q.wakeup)
  `PID_ASSERT(a_mask_nonzero, out_valid_q && res_q.mask_write |-> (res_q.new_mask != 3'd0))
  `PID_ASSERT(a_stall_cause, !s_axis_tready |-> in_valid_q && out_valid_q && !m_axis_tready)

endmodule
